/* design/hwt_pkg.sv */
// Shared types and constants of the hashed timer wheel.
package hwt_pkg;

  localparam int unsigned MAX_TIMERS_DEF = 16;
  localparam logic [15:0] PERIOD_RESET = 16'd10;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_FIRED   = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [31:0] wait_ms;
    logic [62:0] cancel_id;
  } item_t;

endpackage

/* design/hwt_front.sv */
// Input side: accepts items, drops OP_NONE items, and queues the rest for the back end.
module hwt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,
  input  logic [1:0]    s_tuser,
  output logic          q_valid,
  input  logic          q_ready,
  output hwt_pkg::item_t q_item
);

  hwt_pkg::item_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;
  hwt_pkg::item_t in_item;

  assign in_item.op        = hwt_pkg::op_t'(s_tuser);
  assign in_item.wait_ms   = s_tdata[31:0];
  assign in_item.cancel_id = s_tdata[94:32];

  assign s_tready = (fill != 2'd2);
  // Items with op OP_NONE are taken and dropped here.
  assign push     = s_tvalid && s_tready && (in_item.op != hwt_pkg::OP_NONE);
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= in_item;
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/hwt_back.sv */
// Execution side: timer table, delay divider, scans and the registered result stage.
module hwt_back #(
  parameter int unsigned MAX_TIMERS = hwt_pkg::MAX_TIMERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    period,
  input  logic           q_valid,
  output logic           q_ready,
  input  hwt_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [79:0]    m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);

  localparam int unsigned CW = $clog2(MAX_TIMERS + 1);
  localparam int unsigned IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REJECT, ST_DIV, ST_ADDW, ST_SCAN, ST_CNT, ST_FIRE
  } state_t;

  state_t        state;
  logic [62:0]   ident  [MAX_TIMERS];
  logic [63:0]   expiry [MAX_TIMERS];
  logic [CW-1:0] count;
  logic [63:0]   tick;
  logic [62:0]   next_id;
  logic [CW-1:0] idx;
  logic [CW-1:0] nfire;
  logic [CW-1:0] fin;
  logic [62:0]   cid;
  logic [31:0]   dvd;
  logic [15:0]   rem;
  logic [4:0]    step;

  logic [62:0]   o_id;
  logic          o_ok;
  logic [4:0]    o_fired;
  logic [4:0]    o_active;

  logic          can_out;
  logic          out_load;
  logic [IW-1:0] ix;
  logic          at_end;
  logic          due;
  logic [16:0]   trial;
  logic          fits;
  logic          remove;

  function automatic logic [4:0] cnt5(input logic [CW-1:0] v);
    logic [CW+4:0] w;
    w = {5'b0, v};
    return w[4:0];
  endfunction

  assign can_out = !m_tvalid || m_tready;
  assign q_ready = (state == ST_IDLE);
  assign ix      = idx[IW-1:0];
  assign at_end  = (idx == count);
  assign due     = !at_end && (expiry[ix] <= tick);
  assign trial   = {rem, dvd[31]};
  assign fits    = (trial >= {1'b0, period});
  assign remove  = can_out && !at_end &&
                   (((state == ST_SCAN) && (ident[ix] == cid)) ||
                    ((state == ST_FIRE) && due));
  // A new result enters the output register this cycle.
  assign out_load = can_out &&
                    ((state == ST_REJECT) || (state == ST_ADDW) ||
                     ((state == ST_SCAN) && (at_end || (ident[ix] == cid))) ||
                     ((state == ST_FIRE) && (at_end || due)));

  assign m_tdata = {6'b0, o_active, o_fired, o_ok, o_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      tick     <= '0;
      next_id  <= 63'd1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      if (remove) begin
        // Close the gap so the table stays packed in insertion order.
        for (int j = 0; j + 1 < MAX_TIMERS; j++) begin
          if (j >= int'(idx)) begin
            ident[j]  <= ident[j+1];
            expiry[j] <= expiry[j+1];
          end
        end
        count <= count - CW'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            idx   <= '0;
            nfire <= '0;
            cid   <= q_item.cancel_id;
            unique case (q_item.op)
              hwt_pkg::OP_ADD: begin
                if (q_item.wait_ms[31] || (q_item.wait_ms == 32'd0) ||
                    (count == CW'(MAX_TIMERS))) begin
                  state <= ST_REJECT;
                end else begin
                  dvd   <= q_item.wait_ms + {16'd0, period} - 32'd1;
                  rem   <= '0;
                  step  <= '0;
                  state <= ST_DIV;
                end
              end
              hwt_pkg::OP_CANCEL: state <= ST_SCAN;
              hwt_pkg::OP_TICK:   state <= ST_CNT;
              default:            state <= ST_IDLE;
            endcase
          end
        end
        ST_REJECT: begin
          if (can_out) begin
            m_tvalid <= 1'b1;
            m_tuser  <= hwt_pkg::KIND_ADD;
            o_id     <= '0;
            o_ok     <= 1'b0;
            o_fired  <= '0;
            o_active <= cnt5(count);
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_DIV: begin
          // One quotient bit per cycle; the quotient shifts in behind the dividend.
          rem  <= fits ? 16'(trial - {1'b0, period}) : trial[15:0];
          dvd  <= {dvd[30:0], fits};
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= ST_ADDW;
          end
        end
        ST_ADDW: begin
          if (can_out) begin
            ident[count[IW-1:0]]  <= next_id;
            expiry[count[IW-1:0]] <= tick + {32'd0, dvd};
            count    <= count + CW'(1);
            next_id  <= next_id + 63'd1;
            m_tvalid <= 1'b1;
            m_tuser  <= hwt_pkg::KIND_ADD;
            o_id     <= next_id;
            o_ok     <= 1'b1;
            o_fired  <= '0;
            o_active <= cnt5(count + CW'(1));
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (at_end || (ident[ix] == cid)) begin
            if (can_out) begin
              m_tvalid <= 1'b1;
              m_tuser  <= hwt_pkg::KIND_CANCEL;
              o_id     <= cid;
              o_ok     <= !at_end;
              o_fired  <= '0;
              o_active <= cnt5(at_end ? count : count - CW'(1));
              m_tlast  <= 1'b1;
              state    <= ST_IDLE;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_CNT: begin
          // First pass counts the due timers so every result carries the final count.
          if (at_end) begin
            fin   <= count - nfire;
            idx   <= '0;
            state <= ST_FIRE;
          end else begin
            nfire <= nfire + {{(CW-1){1'b0}}, due};
            idx   <= idx + CW'(1);
          end
        end
        ST_FIRE: begin
          if (at_end) begin
            if (can_out) begin
              m_tvalid <= 1'b1;
              m_tuser  <= hwt_pkg::KIND_SUMMARY;
              o_id     <= '0;
              o_ok     <= 1'b1;
              o_fired  <= cnt5(nfire);
              o_active <= cnt5(fin);
              m_tlast  <= 1'b1;
              tick     <= tick + 64'd1;
              state    <= ST_IDLE;
            end
          end else if (due) begin
            if (can_out) begin
              m_tvalid <= 1'b1;
              m_tuser  <= hwt_pkg::KIND_FIRED;
              o_id     <= ident[ix];
              o_ok     <= 1'b1;
              o_fired  <= '0;
              o_active <= cnt5(fin);
              m_tlast  <= 1'b0;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/hashed_timer_wheel.sv */
// Top level of the hashed timer wheel: configuration register, input queue and table engine.
// The block keeps up to MAX_TIMERS pending timers in insertion order. An add runs through
// the bit-serial divider that turns milliseconds into ticks (32 steps); a cancel compares
// one table entry per cycle; a tick makes two passes, one that counts the due timers and
// a second that fires and removes them, one entry per cycle in each pass while the output
// is not stalled. A two-item queue takes new items while the engine works and registers
// each item before the engine sees it; results leave through a registered output stage,
// and output stalls hold the engine back.
module hashed_timer_wheel #(
  parameter int unsigned MAX_TIMERS = hwt_pkg::MAX_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,  // tick_period_ms
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,    // wait_ms[31:0], cancel_id[94:32], zero fill
  input  logic [1:0]  s_tuser,    // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // ident[62:0], ok[63], fired_count[68:64],
                                  // active_count[73:69], zero fill
  output logic [1:0]  m_tuser,    // kind
  output logic        m_tlast     // last
);

  logic [15:0]    period;
  logic [15:0]    period_eff;
  logic           q_valid;
  logic           q_ready;
  hwt_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= hwt_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  // A period of zero behaves as one.
  assign period_eff = (period == 16'd0) ? 16'd1 : period;

  hwt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  hwt_back #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .period   (period_eff),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the hashed timer wheel: timer table scoreboard and stimulus.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = hwt_pkg::MAX_TIMERS_DEF;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    logic [1:0]  kind;
    logic [62:0] ident;
    logic        ok;
    logic [4:0]  fired;
    logic [4:0]  active;
    logic        last;
  } reply_t;

  // Tracks the pending timers and the replies each accepted item must produce.
  class timer_sb;
    logic [15:0] period;
    logic [62:0] ident_tab[SLOTS];
    logic [63:0] expiry_tab[SLOTS];
    int unsigned pending;
    logic [63:0] tick_now;
    logic [62:0] next_ident;
    reply_t      replies_due[$];
    int unsigned errors;

    function new();
      period = hwt_pkg::PERIOD_RESET;
      pending = 0;
      tick_now = '0;
      next_ident = 63'd1;
      errors = 0;
    endfunction

    function void drop_entry(int unsigned pos);
      for (int unsigned i = pos; i + 1 < pending; i++) begin
        ident_tab[i] = ident_tab[i + 1];
        expiry_tab[i] = expiry_tab[i + 1];
      end
      pending--;
    endfunction

    function void push_reply(logic [1:0] kind, logic [62:0] ident, logic ok,
                             logic [4:0] fired, logic last);
      reply_t r;
      r.kind = kind;
      r.ident = ident;
      r.ok = ok;
      r.fired = fired;
      r.active = 5'(pending);
      r.last = last;
      replies_due = {replies_due, r};
    endfunction

    function void note_item(hwt_pkg::op_t op, logic [31:0] wait_ms, logic [62:0] cancel_id);
      logic [63:0] div;
      logic [63:0] ticks;
      logic        found;
      logic [62:0] fired_ids[$];
      int unsigned i;
      case (op)
        hwt_pkg::OP_ADD: begin
          if (wait_ms[31] || wait_ms == 0 || pending >= SLOTS) begin
            push_reply(hwt_pkg::KIND_ADD, '0, 1'b0, '0, 1'b1);
          end else begin
            div = (period == 0) ? 64'd1 : 64'(period);
            ticks = (64'(wait_ms) + div - 1) / div;
            ident_tab[pending] = next_ident;
            expiry_tab[pending] = tick_now + ticks;
            pending++;
            push_reply(hwt_pkg::KIND_ADD, next_ident, 1'b1, '0, 1'b1);
            next_ident = next_ident + 1;
          end
        end
        hwt_pkg::OP_CANCEL: begin
          found = 1'b0;
          for (i = 0; i < pending; i++) begin
            if (ident_tab[i] == cancel_id) begin
              drop_entry(i);
              found = 1'b1;
              break;
            end
          end
          push_reply(hwt_pkg::KIND_CANCEL, cancel_id, found, '0, 1'b1);
        end
        hwt_pkg::OP_TICK: begin
          i = 0;
          while (i < pending) begin
            if (expiry_tab[i] <= tick_now) begin
              fired_ids = {fired_ids, ident_tab[i]};
              drop_entry(i);
            end else begin
              i++;
            end
          end
          // Fired replies carry the count left after the whole tick.
          foreach (fired_ids[k])
            push_reply(hwt_pkg::KIND_FIRED, fired_ids[k], 1'b1, '0, 1'b0);
          push_reply(hwt_pkg::KIND_SUMMARY, '0, 1'b1, 5'(fired_ids.size()), 1'b1);
          tick_now = tick_now + 1;
        end
        default: ;
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply kind=%0d id=%0h", $time, got.kind, got.ident);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.kind !== want.kind || got.ident !== want.ident || got.ok !== want.ok ||
          got.fired !== want.fired || got.active !== want.active ||
          got.last !== want.last) begin
        $display("%0t: mismatch expected kind=%0d id=%0h ok=%0b fired=%0d active=%0d last=%0b",
                 $time, want.kind, want.ident, want.ok, want.fired, want.active, want.last);
        $display("%0t:          actual   kind=%0d id=%0h ok=%0b fired=%0d active=%0d last=%0b",
                 $time, got.kind, got.ident, got.ok, got.fired, got.active, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  timer_sb sb = new();
  bit quiet = 1'b0;
  bit hold_out = 1'b0;
  bit stim_done = 1'b0;

  hashed_timer_wheel dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    reply_t r;
    if (!rst && m_tvalid && m_tready) begin
      r.kind = m_tuser;
      r.ident = m_tdata[62:0];
      r.ok = m_tdata[63];
      r.fired = m_tdata[68:64];
      r.active = m_tdata[73:69];
      r.last = m_tlast;
      sb.check_reply(r);
    end
  end

  task automatic send_item(hwt_pkg::op_t op, logic [31:0] wait_ms, logic [62:0] cancel_id);
    if (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, cancel_id, wait_ms};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, wait_ms, cancel_id);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    // An ignored item is dropped at the input and never reaches the engine.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.period = value;
  endtask

  function automatic logic [62:0] rand_ident();
    return 63'({$urandom, $urandom});
  endfunction

  task automatic random_items(int unsigned count);
    int unsigned pick;
    logic [31:0] span;
    logic [62:0] id;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      span = (sb.period == 0) ? 32'd6 : 32'(sb.period) * 6;
      if (pick < 30) begin
        send_item(hwt_pkg::OP_ADD, $urandom_range(span, 1), '0);
      end else if (pick < 38) begin
        send_item(hwt_pkg::OP_ADD, $urandom, rand_ident());
      end else if (pick < 55) begin
        if (sb.pending != 0 && $urandom_range(3) != 0)
          id = sb.ident_tab[$urandom_range(sb.pending - 1)];
        else
          id = sb.next_ident - 63'($urandom_range(4, 1));
        send_item(hwt_pkg::OP_CANCEL, $urandom, id);
      end else if (pick < 60) begin
        send_item(hwt_pkg::OP_CANCEL, $urandom, rand_ident());
      end else if (pick < 97) begin
        send_item(hwt_pkg::OP_TICK, $urandom, rand_ident());
      end else begin
        send_item(hwt_pkg::OP_NONE, $urandom, rand_ident());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_period(16'd10);

    // Directed: delay edges, rejects, cancels found and missed, ticks, ignored op.
    send_item(hwt_pkg::OP_ADD, 32'd1, '0);
    send_item(hwt_pkg::OP_ADD, 32'd10, '0);
    send_item(hwt_pkg::OP_ADD, 32'd11, '0);
    send_item(hwt_pkg::OP_ADD, 32'd0, '1);
    send_item(hwt_pkg::OP_ADD, 32'hFFFF_FFFF, '0);
    send_item(hwt_pkg::OP_ADD, 32'h8000_0000, '0);
    send_item(hwt_pkg::OP_ADD, 32'h7FFF_FFFF, '0);
    send_item(hwt_pkg::OP_CANCEL, '0, 63'd2);
    send_item(hwt_pkg::OP_CANCEL, '1, 63'd2);
    send_item(hwt_pkg::OP_CANCEL, '0, '1);
    send_item(hwt_pkg::OP_CANCEL, '0, 63'd0);
    send_item(hwt_pkg::OP_TICK, '0, '0);
    send_item(hwt_pkg::OP_TICK, '1, '1);
    send_item(hwt_pkg::OP_TICK, '0, '0);
    send_item(hwt_pkg::OP_NONE, '1, '1);
    send_item(hwt_pkg::OP_TICK, '0, '0);

    // Period zero acts as one; overfill the table while the output is held off.
    write_period(16'd0);
    hold_out = 1'b1;
    for (int unsigned n = 0; n < 18; n++)
      send_item(hwt_pkg::OP_ADD, $urandom_range(3, 1), '0);
    for (int unsigned n = 0; n < 5; n++) send_item(hwt_pkg::OP_TICK, '0, '0);
    s_tvalid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);

    write_period(16'hFFFF);
    random_items(130);
    write_period(16'd1);
    random_items(40);
    quiet = 1'b1;
    random_items(50);
    quiet = 1'b0;
    random_items(40);
    write_period(16'($urandom_range(65535, 2)));
    random_items(130);

    wait_drained();
    if (sb.errors == 0 && sb.replies_due.size() == 0)
      $display("** hashed_timer_wheel: PASSED **");
    else
      $display("** hashed_timer_wheel: FAILED **");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("** hashed_timer_wheel: FAILED **");
    $finish;
  end
endmodule

/* sim.f */
design/hwt_pkg.sv
design/hwt_front.sv
design/hwt_back.sv
design/hashed_timer_wheel.sv
tb/tb_top.sv
